@@ rtl/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// Parity and primality classifier package
// Types and constants of the classifier top level; the status type is also
// used by its remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

   // The smallest trial divisor. Two is tried first, then the odd numbers.
   localparam int unsigned FIRST_DIVISOR = 2;

   // Sequencer states of the classifier.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } ppc_state_type;

   // Status that the remainder unit reports to the sequencer.
   typedef struct packed {
      logic busy;           // a division is in progress
      logic done;           // one-cycle pulse: quotient and remainder are final
      logic rem_zero;       // remainder is zero
      logic bound_exceeded; // divisor is greater than the quotient
   } ppc_div_status_type;

endpackage

`default_nettype wire

@@ rtl/ppc_req_if.sv @@
// ----------------------------------------------------------------------------
// Classifier request channel
// Valid/ready channel that carries one signed integer per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppc_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/ppc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Classifier response channel
// Valid/ready channel that carries the even and prime flags per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppc_rsp_if;
   logic valid;
   logic ready;
   logic is_even;
   logic is_prime;

   modport source (output valid, output is_even, output is_prime, input ready);
   modport sink   (input valid, input is_even, input is_prime, output ready);
endinterface

`default_nettype wire

@@ rtl/ppc_rem_unit.sv @@
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division that takes one dividend bit per cycle. After
// VALUE_WIDTH steps it reports whether the remainder is zero and whether the
// divisor exceeds the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_rem_unit import ppc_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output ppc_div_status_type          status
);

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [VALUE_WIDTH-1:0] rem_ff,   rem_in;
   logic [VALUE_WIDTH-1:0] quot_ff,  quot_in;

   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   // One restoring step: shift the next dividend bit into the partial
   // remainder and subtract the divisor when it fits.
   assign trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   // The quotient register starts as the dividend and fills with quotient
   // bits from the right as the dividend bits leave on the left.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_WIDTH'(VALUE_WIDTH - 1);
         rem_in   = '0;
         quot_in  = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         quot_in  = {quot_ff[VALUE_WIDTH-2:0], fits};
         count_in = count_ff - CNT_WIDTH'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   // Status toward the sequencer.
   always_comb begin
      status.busy           = busy_ff;
      status.done           = done_ff;
      status.rem_zero       = (rem_ff == '0);
      status.bound_exceeded = (divisor > quot_ff);
   end

endmodule

`default_nettype wire

@@ rtl/parity_and_primality_classifier.sv @@
// ----------------------------------------------------------------------------
// Parity and primality classifier
// Classifies one signed integer per request: even flag from the low bit,
// prime flag by trial division with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload                      Handshake
//   req_chan   in         value (VALUE_WIDTH, signed)  valid/ready
//   rsp_chan   out        is_even, is_prime            valid/ready
//
// Each trial divisor is one division in the shared bit-serial remainder
// unit. Divisors tried are 2 and then the odd numbers up to the square root
// of the value; negative values, zero and one skip the divisions. Reset is
// synchronous and leaves the block idle. A request is taken only when the
// classifier is idle; the result register lets the next request start while
// a finished result waits for its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module parity_and_primality_classifier import ppc_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   ppc_req_if.sink  req_chan,
   ppc_rsp_if.source rsp_chan
);

   ppc_state_type          state_ff,   state_in;
   logic [VALUE_WIDTH-1:0] value_ff,   value_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic                   even_ff,    even_in;
   logic                   prime_ff,   prime_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_even_ff,  rsp_even_in;
   logic                   rsp_prime_ff, rsp_prime_in;

   logic                   req_xfer;
   logic                   rsp_free;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] req_bits;
   logic                   req_trivial;
   ppc_div_status_type     div_status;

   // Shared remainder unit.
   ppc_rem_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_rem_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_ff),
      .divisor  (divisor_ff),
      .status   (div_status)
   );

   assign req_bits    = req_chan.value;
   assign req_xfer    = req_chan.valid && req_chan.ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   // Negative values, zero and one are never prime.
   assign req_trivial = req_bits[VALUE_WIDTH-1] || (req_bits[VALUE_WIDTH-1:1] == '0);

   // Sequencer: accept, run trial divisions, hand the flags to the result
   // register.
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      divisor_in   = divisor_ff;
      even_in      = even_ff;
      prime_in     = prime_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_even_in  = rsp_even_ff;
      rsp_prime_in = rsp_prime_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               value_in   = req_bits;
               even_in    = !req_bits[0];
               prime_in   = 1'b0;
               divisor_in = VALUE_WIDTH'(FIRST_DIVISOR);
               state_in   = req_trivial ? ST_FINISH : ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               if (div_status.bound_exceeded) begin
                  prime_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (div_status.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // After two, only odd divisors can be the smallest factor.
                  if (divisor_ff == VALUE_WIDTH'(FIRST_DIVISOR)) begin
                     divisor_in = divisor_ff + VALUE_WIDTH'(1);
                  end else begin
                     divisor_in = divisor_ff + VALUE_WIDTH'(2);
                  end
                  state_in = ST_START;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_even_in  = even_ff;
               rsp_prime_in = prime_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      divisor_ff   <= divisor_in;
      even_ff      <= even_in;
      prime_ff     <= prime_in;
      rsp_even_ff  <= rsp_even_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // Channel outputs.
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_even  = rsp_even_ff;
   assign rsp_chan.is_prime = rsp_prime_ff;

   // A division is never started while the remainder unit is still busy.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("division started while remainder unit busy");

   // An accepted request either finishes at once or starts with divisor two.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_FINISH) ||
                   (state_ff == ST_START && divisor_ff == VALUE_WIDTH'(FIRST_DIVISOR)))
      else $error("request did not start trial division at divisor two");

   // A negative value is never reported prime.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && value_ff[VALUE_WIDTH-1]) |-> !prime_ff)
      else $error("negative value flagged prime");

   // The unit reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_WAIT))
      else $error("division finished outside of the wait state");

endmodule

`default_nettype wire
